// File: sv/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg: shared types and constants of the archive directory parser
// Status codes, parse phases, the signature table and the request records
// passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package adp_pkg;

    // result status codes
    localparam logic [2:0] ST_ENTRY      = 3'd0;
    localparam logic [2:0] ST_NO_ENTRIES = 3'd1;
    localparam logic [2:0] ST_TOO_SMALL  = 3'd2;
    localparam logic [2:0] ST_BAD_SIG    = 3'd3;
    localparam logic [2:0] ST_DIR_TRUNC  = 3'd4;
    localparam logic [2:0] ST_ENTRY_OVER = 3'd5;

    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned SIG_LEN    = 12;
    localparam int unsigned NAME_LEN   = 12;
    localparam int unsigned ENTRY_SH   = 4;   // log2 of the entry size

    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
        8'h4B, 8'h65, 8'h6E, 8'h53, 8'h69, 8'h6C,
        8'h76, 8'h65, 8'h72, 8'h6D, 8'h61, 8'h6E
    };

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE  = 8'h20;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_ENTRIES = 3'b010,
        PH_DONE    = 3'b100
    } t_phase;

    // request from the front: raw entry fields
    typedef struct packed {
        logic [2:0]              status;
        logic [31:0]             index;
        logic [8*NAME_LEN-1:0]   name;
        logic [31:0]             offset;
        logic [31:0]             size;
        logic                    last;
    } t_rec;

    // finished result as shown on the ports
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] index;
        logic [63:0] name_lo;
        logic [31:0] name_hi;
        logic [3:0]  name_len;
        logic [31:0] offset;
        logic [31:0] size;
        logic        last;
    } t_res;

endpackage

// File: sv/adp_front.sv
// ----------------------------------------------------------------------------
// adp_front: byte-level header and directory parser
// Walks the blob one byte per cycle while accepted, checks length, signature
// and directory fit, collects 16-byte entries, one request per finished check.
// ----------------------------------------------------------------------------
module adp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first_byte,
    input  logic [31:0]         i_blob_length,
    output logic                o_rec_valid,
    output adp_pkg::t_rec       o_rec
);

    adp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [3:0]      r_pos, n_pos, e_pos;
    logic            r_sig, n_sig, e_sig;
    logic [31:0]     r_word, n_word;
    logic [31:0]     r_left, n_left;
    logic [31:0]     r_index, n_index;
    logic [31:0]     r_offset, n_offset;
    logic [7:0]      r_name [adp_pkg::NAME_LEN];

    logic [31:0]     w_full_word;
    logic [36:0]     w_dir_end;
    logic [32:0]     w_sum;
    logic            w_sig_ok;

    always_comb begin
        w_full_word = {i_data_byte, r_word[23:0]};
        w_dir_end   = {1'b0, w_full_word, 4'b0000} + 37'(adp_pkg::HDR_BYTES);
        w_sum       = {1'b0, r_offset} + {1'b0, w_full_word};
    end

    always_comb begin
        e_phase = r_phase;
        e_pos   = r_pos;
        e_sig   = r_sig;
        if (i_first_byte) begin
            e_phase = adp_pkg::PH_HEADER;
            e_pos   = '0;
            e_sig   = 1'b1;
        end

        n_phase  = r_phase;
        n_pos    = r_pos;
        n_sig    = r_sig;
        n_word   = r_word;
        n_left   = r_left;
        n_index  = r_index;
        n_offset = r_offset;
        w_sig_ok = 1'b1;

        o_rec_valid = 1'b0;
        o_rec       = '0;
        for (int i = 0; i < adp_pkg::NAME_LEN; i++) begin
            o_rec.name[8*i +: 8] = r_name[i];
        end
        o_rec.index  = r_index;
        o_rec.offset = r_offset;
        o_rec.size   = w_full_word;

        if (i_accept) begin
            n_phase = e_phase;
            n_pos   = e_pos;
            n_sig   = e_sig;
            unique case (e_phase)
                adp_pkg::PH_HEADER: begin
                    o_rec.name   = '0;
                    o_rec.index  = '0;
                    o_rec.offset = '0;
                    o_rec.size   = '0;
                    o_rec.last   = 1'b1;
                    if (e_pos == 4'd0 && i_blob_length < 32'(adp_pkg::HDR_BYTES)) begin
                        n_phase      = adp_pkg::PH_DONE;
                        o_rec_valid  = 1'b1;
                        o_rec.status = adp_pkg::ST_TOO_SMALL;
                    end else if (e_pos < 4'(adp_pkg::SIG_LEN)) begin
                        w_sig_ok = e_sig && (i_data_byte == adp_pkg::SIG_BYTES[e_pos]);
                        n_sig    = w_sig_ok;
                        n_pos    = e_pos + 4'd1;
                        if (e_pos == 4'(adp_pkg::SIG_LEN - 1) && !w_sig_ok) begin
                            n_phase      = adp_pkg::PH_DONE;
                            o_rec_valid  = 1'b1;
                            o_rec.status = adp_pkg::ST_BAD_SIG;
                        end
                    end else if (e_pos != 4'd15) begin
                        n_word[8*e_pos[1:0] +: 8] = i_data_byte;
                        n_pos = e_pos + 4'd1;
                    end else begin
                        n_pos = '0;
                        if ({5'b0, i_blob_length} < w_dir_end) begin
                            n_phase      = adp_pkg::PH_DONE;
                            o_rec_valid  = 1'b1;
                            o_rec.status = adp_pkg::ST_DIR_TRUNC;
                        end else if (w_full_word == '0) begin
                            n_phase      = adp_pkg::PH_DONE;
                            o_rec_valid  = 1'b1;
                            o_rec.status = adp_pkg::ST_NO_ENTRIES;
                        end else begin
                            n_phase  = adp_pkg::PH_ENTRIES;
                            n_left   = w_full_word;
                            n_index  = '0;
                            n_offset = w_dir_end[31:0];
                        end
                    end
                end
                adp_pkg::PH_ENTRIES: begin
                    if (e_pos < 4'(adp_pkg::NAME_LEN)) begin
                        n_pos = e_pos + 4'd1;
                    end else if (e_pos != 4'd15) begin
                        n_word[8*e_pos[1:0] +: 8] = i_data_byte;
                        n_pos = e_pos + 4'd1;
                    end else begin
                        n_pos       = '0;
                        o_rec_valid = 1'b1;
                        if (w_sum > {1'b0, i_blob_length}) begin
                            n_phase      = adp_pkg::PH_DONE;
                            o_rec.status = adp_pkg::ST_ENTRY_OVER;
                            o_rec.last   = 1'b1;
                        end else begin
                            o_rec.status = adp_pkg::ST_ENTRY;
                            o_rec.last   = (r_left == 32'd1);
                            n_offset     = w_sum[31:0];
                            n_index      = r_index + 32'd1;
                            n_left       = r_left - 32'd1;
                            if (r_left == 32'd1) begin
                                n_phase = adp_pkg::PH_DONE;
                            end
                        end
                    end
                end
                adp_pkg::PH_DONE: begin
                    // drop bytes until the next blob starts
                end
                default: begin
                    n_phase = adp_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adp_pkg::PH_HEADER;
            r_pos   <= '0;
            r_sig   <= 1'b1;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sig   <= n_sig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_left   <= n_left;
        r_index  <= n_index;
        r_offset <= n_offset;
        if (i_accept && e_phase == adp_pkg::PH_ENTRIES && e_pos < 4'(adp_pkg::NAME_LEN)) begin
            r_name[e_pos] <= i_data_byte;
        end
    end

endmodule

// File: sv/adp_fifo.sv
// ----------------------------------------------------------------------------
// adp_fifo: short request queue between front and back
// Holds parsed requests so that the parser and the formatter stall apart.
// ----------------------------------------------------------------------------
module adp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  adp_pkg::t_rec       i_wr_rec,
    input  logic                i_rd,
    output adp_pkg::t_rec       o_rd_rec,
    output logic                o_empty,
    output logic                o_full
);

    adp_pkg::t_rec                  r_mem [adp_pkg::QDEPTH];
    logic [adp_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [adp_pkg::QCNT_W-1:0]     r_count;

    assign o_empty  = (r_count == '0);
    assign o_full   = (r_count == adp_pkg::QCNT_W'(adp_pkg::QDEPTH));
    assign o_rd_rec = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == adp_pkg::QPTR_W'(adp_pkg::QDEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == adp_pkg::QPTR_W'(adp_pkg::QDEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |-> !i_wr)
        else $error("request written into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_rd)
        else $error("request read from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= adp_pkg::QCNT_W'(adp_pkg::QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// File: sv/adp_back.sv
// ----------------------------------------------------------------------------
// adp_back: entry formatter and result register
// Trims trailing NUL and space bytes, lowercases the name and holds the
// finished result until it is popped.
// ----------------------------------------------------------------------------
module adp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  adp_pkg::t_rec       i_q_rec,
    output logic                o_q_rd,
    input  logic                i_pop,
    output logic                o_valid,
    output adp_pkg::t_res       o_res
);

    logic          r_valid;
    adp_pkg::t_res r_res, n_res;
    logic [3:0]    w_len;
    logic [7:0]    w_ch;
    logic [8*adp_pkg::NAME_LEN-1:0] w_name;

    assign o_q_rd  = !i_q_empty && (!r_valid || i_pop);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        // last non-blank byte sets the length
        w_len = '0;
        for (int i = 0; i < adp_pkg::NAME_LEN; i++) begin
            if (i_q_rec.name[8*i +: 8] != adp_pkg::CH_NUL &&
                i_q_rec.name[8*i +: 8] != adp_pkg::CH_SPACE) begin
                w_len = 4'(i + 1);
            end
        end
        w_name = '0;
        w_ch   = '0;
        for (int i = 0; i < adp_pkg::NAME_LEN; i++) begin
            w_ch = i_q_rec.name[8*i +: 8];
            if (w_ch >= adp_pkg::CH_UP_A && w_ch <= adp_pkg::CH_UP_Z) begin
                w_ch = w_ch + adp_pkg::CH_CASE;
            end
            if (4'(i) < w_len) begin
                w_name[8*i +: 8] = w_ch;
            end
        end
        n_res.status   = i_q_rec.status;
        n_res.index    = i_q_rec.index;
        n_res.name_lo  = w_name[63:0];
        n_res.name_hi  = w_name[95:64];
        n_res.name_len = w_len;
        n_res.offset   = i_q_rec.offset;
        n_res.size     = i_q_rec.size;
        n_res.last     = i_q_rec.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_res <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.name_len <= 4'(adp_pkg::NAME_LEN)))
        else $error("name length beyond twelve");

    a_empty_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.name_len == '0) |-> (r_res.name_lo == '0 && r_res.name_hi == '0))
        else $error("trimmed name carries bytes");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.status != adp_pkg::ST_ENTRY) |-> r_res.last)
        else $error("error or summary result without last");
`endif

endmodule

// File: sv/archive_directory_parser_core.sv
// ----------------------------------------------------------------------------
// archive_directory_parser_core: streaming archive directory parser
// Checks the header of an archive blob and reports each directory entry.
// ----------------------------------------------------------------------------
// The block takes one blob byte per cycle, sustained, whenever full is low;
// first_byte restarts the parse. A result is registered first in the queue and
// then in the result register: the parser issues a request into a two-deep
// queue, and the formatter trims and lowercases the name into the result
// register read through empty and pop. A new entry completes at most once
// every 16 bytes, so full rises only when results are left unpopped.
// Write blob_length through the cfg channel (always ready) while idle.
module archive_directory_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [31:0] o_entry_index,
    output logic [63:0] o_name_low_bytes,
    output logic [31:0] o_name_high_bytes,
    output logic [3:0]  o_name_length,
    output logic [31:0] o_entry_offset,
    output logic [31:0] o_entry_size,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]   r_blob_len;
    logic          w_accept;
    logic          w_rec_valid;
    adp_pkg::t_rec w_rec;
    adp_pkg::t_rec w_q_rec;
    logic          w_q_empty;
    logic          w_q_full;
    logic          w_q_rd;
    logic          w_out_valid;
    adp_pkg::t_res w_res;

    assign o_cfg_ready = 1'b1;
    assign full        = w_q_full;
    assign w_accept    = push && !w_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blob_len <= '0;
        end else if (i_cfg_valid) begin
            r_blob_len <= i_cfg_data;
        end
    end

    adp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_blob_length (r_blob_len),
        .o_rec_valid   (w_rec_valid),
        .o_rec         (w_rec)
    );

    adp_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_rec_valid),
        .i_wr_rec (w_rec),
        .i_rd     (w_q_rd),
        .o_rd_rec (w_q_rec),
        .o_empty  (w_q_empty),
        .o_full   (w_q_full)
    );

    adp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_rec   (w_q_rec),
        .o_q_rd    (w_q_rd),
        .i_pop     (pop),
        .o_valid   (w_out_valid),
        .o_res     (w_res)
    );

    assign empty             = !w_out_valid;
    assign o_status          = w_res.status;
    assign o_entry_index     = w_res.index;
    assign o_name_low_bytes  = w_res.name_lo;
    assign o_name_high_bytes = w_res.name_hi;
    assign o_name_length     = w_res.name_len;
    assign o_entry_offset    = w_res.offset;
    assign o_entry_size      = w_res.size;
    assign o_last            = w_res.last;

`ifndef SYNTHESIS
    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_blob_len == $past(i_cfg_data)))
        else $error("blob length write lost");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !w_accept)
        else $error("byte accepted while full");

    a_no_lost_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rec_valid |-> (!w_q_full || w_q_rd))
        else $error("request dropped at the queue");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of archive_directory_parser_core
// Streams archive blobs one byte per request into the parser and checks each
// result field by field against an in-bench model of the header, directory
// and entry checks. Blob length settings, idle and stall patterns vary by
// phase; a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES     = 10;
    localparam int PAUSE_PHASE    = 5;

    localparam logic [31:0] PHASE_LEN [NUM_PHASES] = '{
        32'd0, 32'd16, 32'd17, 32'd100, 32'd300,
        32'd1000, 32'd4096, 32'hFFFF_FFFF, 32'd64, 32'd2000
    };
    localparam int PHASE_BUDGET [NUM_PHASES] = '{
        15, 50, 50, 170, 200, 200, 200, 200, 120, 170
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        empty;
    logic        pop;
    logic [2:0]  o_status;
    logic [31:0] o_entry_index;
    logic [63:0] o_name_low_bytes;
    logic [31:0] o_name_high_bytes;
    logic [3:0]  o_name_length;
    logic [31:0] o_entry_offset;
    logic [31:0] o_entry_size;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    int send_idle_pct;
    int recv_stall_pct;

    archive_directory_parser_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_first_byte     (i_first_byte),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_entry_index    (o_entry_index),
        .o_name_low_bytes (o_name_low_bytes),
        .o_name_high_bytes(o_name_high_bytes),
        .o_name_length    (o_name_length),
        .o_entry_offset   (o_entry_offset),
        .o_entry_size     (o_entry_size),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // Tracks the parse of the byte stream and holds the directory results
    // still owed by the block.
    class dir_scoreboard;
        logic [31:0]     blob_len;
        adp_pkg::t_phase phase;
        int unsigned     pos;
        bit              sig_ok;
        logic [31:0]     word;
        logic [31:0]     entries_left;
        logic [31:0]     entry_idx;
        logic [33:0]     run_offset;
        logic [7:0]      name_buf [adp_pkg::NAME_LEN];
        adp_pkg::t_res   pending_results [$];
        int              errors;

        function new();
            blob_len = '0;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            phase        = adp_pkg::PH_HEADER;
            pos          = 0;
            sig_ok       = 1'b1;
            word         = '0;
            entries_left = '0;
            entry_idx    = '0;
            run_offset   = '0;
            foreach (name_buf[i]) name_buf[i] = adp_pkg::CH_NUL;
        endfunction

        function void owe_result(adp_pkg::t_res r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function adp_pkg::t_res header_result(logic [2:0] st);
            adp_pkg::t_res r;
            r        = '0;
            r.status = st;
            r.last   = 1'b1;
            return r;
        endfunction

        function adp_pkg::t_res entry_result(logic [2:0] st, logic [31:0] size, bit fin);
            adp_pkg::t_res r;
            int            len;
            logic [7:0]    c;
            r   = '0;
            len = adp_pkg::NAME_LEN;
            // drop trailing NUL and space bytes
            while (len > 0 && (name_buf[len-1] == adp_pkg::CH_NUL ||
                               name_buf[len-1] == adp_pkg::CH_SPACE))
                len--;
            for (int i = 0; i < len; i++) begin
                c = name_buf[i];
                if (c >= adp_pkg::CH_UP_A && c <= adp_pkg::CH_UP_Z) c = c + adp_pkg::CH_CASE;
                if (i < 8) r.name_lo[8*i +: 8] = c;
                else r.name_hi[8*(i-8) +: 8] = c;
            end
            r.status   = st;
            r.index    = entry_idx;
            r.name_len = len[3:0];
            r.offset   = run_offset[31:0];
            r.size     = size;
            r.last     = fin;
            return r;
        endfunction

        function void note_byte(logic [7:0] b, bit first);
            logic [39:0] dir_end;
            logic [31:0] size;
            if (first) restart();
            if (phase == adp_pkg::PH_DONE) return;
            if (phase == adp_pkg::PH_HEADER) begin
                if (pos == 0 && blob_len < adp_pkg::HDR_BYTES) begin
                    phase = adp_pkg::PH_DONE;
                    owe_result(header_result(adp_pkg::ST_TOO_SMALL));
                    return;
                end
                if (pos < adp_pkg::SIG_LEN) begin
                    if (b != adp_pkg::SIG_BYTES[pos]) sig_ok = 1'b0;
                    pos++;
                    if (pos == adp_pkg::SIG_LEN && !sig_ok) begin
                        phase = adp_pkg::PH_DONE;
                        owe_result(header_result(adp_pkg::ST_BAD_SIG));
                    end
                    return;
                end
                word = word | (32'(b) << (8 * (pos - adp_pkg::SIG_LEN)));
                if (pos < adp_pkg::HDR_BYTES - 1) begin
                    pos++;
                    return;
                end
                pos     = 0;
                dir_end = 40'(adp_pkg::HDR_BYTES) + (40'(word) << adp_pkg::ENTRY_SH);
                if (40'(blob_len) < dir_end) begin
                    phase = adp_pkg::PH_DONE;
                    owe_result(header_result(adp_pkg::ST_DIR_TRUNC));
                end else if (word == 0) begin
                    phase = adp_pkg::PH_DONE;
                    owe_result(header_result(adp_pkg::ST_NO_ENTRIES));
                end else begin
                    entries_left = word;
                    entry_idx    = '0;
                    run_offset   = dir_end[33:0];
                    word         = '0;
                    phase        = adp_pkg::PH_ENTRIES;
                end
                return;
            end
            if (pos < adp_pkg::NAME_LEN) begin
                name_buf[pos] = b;
                if (pos == 0) word = '0;
                pos++;
                return;
            end
            word = word | (32'(b) << (8 * (pos - adp_pkg::NAME_LEN)));
            if (pos < adp_pkg::HDR_BYTES - 1) begin
                pos++;
                return;
            end
            pos  = 0;
            size = word;
            word = '0;
            if (36'(run_offset) + 36'(size) > 36'(blob_len)) begin
                phase = adp_pkg::PH_DONE;
                owe_result(entry_result(adp_pkg::ST_ENTRY_OVER, size, 1'b1));
                return;
            end
            owe_result(entry_result(adp_pkg::ST_ENTRY, size, entries_left == 1));
            run_offset   = run_offset + 34'(size);
            entry_idx    = entry_idx + 1;
            entries_left = entries_left - 1;
            if (entries_left == 0) phase = adp_pkg::PH_DONE;
        endfunction

        function void check_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s: expected %0h, actual %0h", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(adp_pkg::t_res got);
            adp_pkg::t_res want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d index %0d", got.status, got.index);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("entry_index", want.index, got.index);
            check_field("name_low_bytes", want.name_lo, got.name_lo);
            check_field("name_high_bytes", want.name_hi, got.name_hi);
            check_field("name_length", want.name_len, got.name_len);
            check_field("entry_offset", want.offset, got.offset);
            check_field("entry_size", want.size, got.size);
            check_field("last", want.last, got.last);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    dir_scoreboard sb;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // random backpressure on the result side
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            sb.check_result({o_status, o_entry_index, o_name_low_bytes, o_name_high_bytes,
                             o_name_length, o_entry_offset, o_entry_size, o_last});
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, bit first);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_byte(b, first);
    endtask

    task automatic send_blob(logic [7:0] q[$], bit mark_first);
        foreach (q[i]) send_byte(q[i], mark_first && i == 0);
    endtask

    // hold off until every result has come back, then let the pipe settle
    task automatic drain_results();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_blob_length(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.blob_len = v;
    endtask

    // Mostly well-formed blobs with random names and sizes; some carry a bad
    // signature, an oversized count or entry, a cut, trailing junk, or noise.
    task automatic build_blob(ref logic [7:0] q[$], input logic [31:0] len);
        int unsigned kind;
        int unsigned pick;
        int unsigned n_ent;
        int unsigned cut;
        int unsigned nl;
        logic [31:0] count;
        logic [31:0] max_fit;
        logic [31:0] size;
        logic [63:0] off;
        logic [63:0] rem;
        q.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(40, 1)) q.insert(q.size(), 8'($urandom()));
            return;
        end
        for (int k = 0; k < adp_pkg::SIG_LEN; k++) q.insert(q.size(), adp_pkg::SIG_BYTES[k]);
        if (kind < 18) begin
            pick    = $urandom_range(adp_pkg::SIG_LEN - 1);
            q[pick] = q[pick] ^ 8'($urandom_range(255, 1));
        end
        max_fit = (len >= adp_pkg::HDR_BYTES) ?
                  (len - adp_pkg::HDR_BYTES) >> adp_pkg::ENTRY_SH : '0;
        pick    = $urandom_range(99);
        if (pick < 8) count = '0;
        else if (pick < 16) count = max_fit + 1;
        else if (pick < 22) count = $urandom();
        else if (max_fit == 0) count = '0;
        else count = $urandom_range((max_fit < 5) ? max_fit : 5, 1);
        for (int k = 0; k < 4; k++) q.insert(q.size(), count[8*k +: 8]);
        n_ent = (count <= max_fit) ? ((count < 6) ? count : 6) : 0;
        off   = 64'(adp_pkg::HDR_BYTES) + (64'(count) << adp_pkg::ENTRY_SH);
        for (int e = 0; e < n_ent; e++) begin
            nl = $urandom_range(adp_pkg::NAME_LEN);
            for (int j = 0; j < adp_pkg::NAME_LEN; j++) begin
                if (j < nl) begin
                    case ($urandom_range(3))
                        0: q.insert(q.size(), adp_pkg::CH_UP_A + 8'($urandom_range(25)));
                        1: q.insert(q.size(), adp_pkg::CH_UP_A + adp_pkg::CH_CASE +
                                              8'($urandom_range(25)));
                        2: q.insert(q.size(), 8'($urandom()));
                        default: q.insert(q.size(), adp_pkg::CH_SPACE);
                    endcase
                end else begin
                    q.insert(q.size(), $urandom_range(1) ? adp_pkg::CH_NUL : adp_pkg::CH_SPACE);
                end
            end
            rem  = (off <= 64'(len)) ? 64'(len) - off : '0;
            pick = $urandom_range(99);
            if (pick < 8) size = rem[31:0] + 1;
            else if (pick < 13) size = $urandom();
            else if (pick < 20) size = rem[31:0];
            else size = $urandom_range(rem[31:0] >> 1, 0);
            for (int k = 0; k < 4; k++) q.insert(q.size(), size[8*k +: 8]);
            off = off + 64'(size);
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(q.size() - 1, 1);
            while (q.size() > cut) q.delete(q.size() - 1);
        end
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(3, 1)) q.insert(q.size(), 8'($urandom()));
    endtask

    initial begin : stimulus
        logic [7:0] blob [$];
        int         sent;
        bit         paused;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_data_byte    = '0;
        i_first_byte   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blob too small, first without and then with the restart flag
        write_blob_length(32'd8);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_results();

        // empty directory, then a signature that fails on its last byte
        write_blob_length(32'd16);
        for (int k = 0; k < adp_pkg::SIG_LEN; k++) blob.insert(blob.size(), adp_pkg::SIG_BYTES[k]);
        repeat (4) blob.insert(blob.size(), 8'h00);
        send_blob(blob, 1'b1);
        blob.delete();
        for (int k = 0; k < adp_pkg::SIG_LEN; k++) blob.insert(blob.size(), adp_pkg::SIG_BYTES[k]);
        blob[adp_pkg::SIG_LEN-1] = 8'h00;
        send_blob(blob, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_blob_length(PHASE_LEN[ph]);
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 53;
                end
                default: begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_BUDGET[ph]) begin
                build_blob(blob, PHASE_LEN[ph]);
                send_blob(blob, $urandom_range(9) != 0);
                sent += blob.size();
                if (ph == PAUSE_PHASE && !paused && 2 * sent >= PHASE_BUDGET[ph]) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
sv/adp_pkg.sv
sv/adp_front.sv
sv/adp_fifo.sv
sv/adp_back.sv
sv/archive_directory_parser_core.sv
sim/tb.sv
